// File: hdl/mpts_pkg.sv
package mpts_pkg;
  localparam int MAX_THREADS_DEF = 16;
  localparam int SLICE_FACTOR = 10;
  localparam logic [11:0] FCFS_SLICE = 12'd1000;

  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_SCHED = 2'd1;
  localparam logic [1:0] CMD_YIELD = 2'd2;

  localparam logic [1:0] OUT_RUN = 2'd0;
  localparam logic [1:0] OUT_DEAD = 2'd1;

  localparam logic [1:0] POL_PRIO = 2'd1;
  localparam logic [1:0] POL_FCFS = 2'd2;

  localparam logic [1:0] ST_CREATED = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SWITCHED = 2'd2;
  localparam logic [1:0] ST_NOSWITCH = 2'd3;
endpackage

// File: hdl/multi_policy_thread_scheduler.sv
// flow: create probes slots from 0 upward for a free one; schedule/yield scan the ready list (outgoing
// thread included) for the pick, then shift the entries behind it down; an empty list ends the scan at once;
// yield on an empty list or a bad command goes straight to the result
// throughput: one item at a time; the next item is accepted the cycle after the engine moves its
// result into the output register; a result still waiting there stalls the engine
// reset: synchronous active low; busy bits, list length, running thread, arrival counter, policy clear at once
module multi_policy_thread_scheduler #(
  parameter int MAX_THREADS = mpts_pkg::MAX_THREADS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_priority_req,
  input  logic [1:0]  in_outgoing_state,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_pid,
  output logic [11:0] out_slice_ticks,
  output logic        out_slot_freed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_policy
);
  import mpts_pkg::*;

  localparam int PW = $clog2(MAX_THREADS);
  localparam int LW = $clog2(MAX_THREADS + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_FIND  = 8'b00000010,
    S_SCAN  = 8'b00000100,
    S_SCANW = 8'b00001000,
    S_PSL   = 8'b00010000,
    S_SHIFT = 8'b00100000,
    S_SHW   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] policy_r;
  logic [MAX_THREADS-1:0] busy_r;
  logic [LW-1:0] len_r;
  logic [PW-1:0] cur_pid_r;
  logic cur_valid_r;
  logic [31:0] order_r;
  logic [PW-1:0] find_r;
  logic [LW-1:0] idx_r, best_r;
  logic [PW-1:0] cand_pid_r;
  logic [PW-1:0] best_pid_r;
  logic [7:0] best_prio_r;
  logic [31:0] best_ord_r;
  logic [7:0] preq_r;
  // result being built by the engine
  logic [1:0] w_st_r;
  logic [3:0] w_pid_r;
  logic [11:0] w_sl_r;
  logic w_fr_r;
  // output register
  logic ov_r;
  logic [1:0] ost_r;
  logic [3:0] opid_r;
  logic [11:0] osl_r;
  logic ofr_r;

  // rams
  logic pr_we, od_we, rl_we;
  logic [PW-1:0] pr_wa, pr_ra, rl_wa, rl_ra;
  logic [7:0] pr_wd, pr_rd;
  logic [31:0] od_rd;
  logic [PW-1:0] rl_wd, rl_rd;

  mpts_ram #(.WIDTH(8), .DEPTH(MAX_THREADS)) u_prio (
    .clk, .we(pr_we), .waddr(pr_wa), .wdata(pr_wd), .raddr(pr_ra), .rdata(pr_rd));
  mpts_ram #(.WIDTH(32), .DEPTH(MAX_THREADS)) u_order (
    .clk, .we(od_we), .waddr(pr_wa), .wdata(order_r), .raddr(pr_ra), .rdata(od_rd));
  mpts_ram #(.WIDTH(PW), .DEPTH(MAX_THREADS)) u_list (
    .clk, .we(rl_we), .waddr(rl_wa), .wdata(rl_wd), .raddr(rl_ra), .rdata(rl_rd));

  logic out_free;
  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_pid = opid_r;
  assign out_slice_ticks = osl_r;
  assign out_slot_freed = ofr_r;

  logic acc;
  assign acc = in_valid && in_ready;

  logic [LW-1:0] len_nxt, idx_nxt;
  logic better;
  always_comb begin
    better = 1'b0;
    if (policy_r == POL_PRIO) better = pr_rd > best_prio_r;
    else if (policy_r == POL_FCFS) better = od_rd < best_ord_r;
  end

  logic [11:0] slice_v;
  assign slice_v = (policy_r == POL_FCFS) ? FCFS_SLICE : 12'(best_prio_r * SLICE_FACTOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      policy_r <= 2'd0;
      busy_r <= '0;
      len_r <= '0;
      cur_pid_r <= '0;
      cur_valid_r <= 1'b0;
      order_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      idx_r <= idx_nxt;
      if (cfg_valid && cfg_ready) policy_r <= cfg_policy;
      if (state_r == S_DONE && out_free) begin
        ov_r <= 1'b1;
        ost_r <= w_st_r;
        opid_r <= w_pid_r;
        osl_r <= w_sl_r;
        ofr_r <= w_fr_r;
      end else if (out_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (acc) begin
          find_r <= '0;
          preq_r <= in_priority_req;
          w_st_r <= ST_NOSWITCH;
          w_pid_r <= cur_valid_r ? 4'(cur_pid_r) : 4'd0;
          w_sl_r <= '0;
          w_fr_r <= (in_cmd == CMD_SCHED) && cur_valid_r && (in_outgoing_state == OUT_DEAD);
          if (in_cmd == CMD_SCHED && cur_valid_r) begin
            if (in_outgoing_state == OUT_DEAD) busy_r[cur_pid_r] <= 1'b0;
            // runnable thread keeps running only when nobody else waits
            if (in_outgoing_state != OUT_RUN || len_r != '0) cur_valid_r <= 1'b0;
          end else if (in_cmd == CMD_YIELD && len_r != '0) cur_valid_r <= 1'b0;
        end
        S_FIND: begin
          if (!busy_r[find_r]) begin
            busy_r[find_r] <= 1'b1;
            order_r <= order_r + 32'd1;
            w_st_r <= ST_CREATED;
            w_pid_r <= 4'(find_r);
            w_sl_r <= 12'(preq_r * SLICE_FACTOR);
          end else if (find_r == PW'(MAX_THREADS - 1)) begin
            w_st_r <= ST_FULL;
            w_pid_r <= '0;
          end else find_r <= find_r + PW'(1);
        end
        S_SCAN: begin
          // prio/order of the candidate fetched last cycle are out now
          if (idx_r != '0 && (idx_r == LW'(1) || better)) begin
            best_r <= idx_r - LW'(1);
            best_pid_r <= cand_pid_r;
            best_prio_r <= pr_rd;
            best_ord_r <= od_rd;
          end
          if (len_r == '0) w_pid_r <= cur_valid_r ? 4'(cur_pid_r) : 4'd0;
        end
        S_SCANW: cand_pid_r <= rl_rd;
        S_PSL: begin
          cur_pid_r <= best_pid_r;
          cur_valid_r <= 1'b1;
          w_st_r <= ST_SWITCHED;
          w_pid_r <= 4'(best_pid_r);
          w_sl_r <= slice_v;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt = len_r;
    idx_nxt = idx_r;
    pr_we = 1'b0; od_we = 1'b0; rl_we = 1'b0;
    pr_wa = find_r; pr_wd = preq_r;
    pr_ra = rl_rd;
    rl_wa = len_r[PW-1:0]; rl_wd = find_r; rl_ra = idx_r[PW-1:0];
    unique case (state_r)
      S_IDLE: if (acc) begin
        idx_nxt = '0;
        if (in_cmd == CMD_CREATE) state_nxt = S_FIND;
        else if (in_cmd == CMD_SCHED) begin
          state_nxt = S_SCAN;
          // runnable thread goes to the tail when others wait
          if (cur_valid_r && in_outgoing_state == OUT_RUN && len_r != '0) begin
            rl_we = 1'b1; rl_wd = cur_pid_r; len_nxt = len_r + LW'(1);
          end
        end else if (in_cmd == CMD_YIELD && len_r != '0) begin
          state_nxt = S_SCAN;
          if (cur_valid_r) begin
            rl_we = 1'b1; rl_wd = cur_pid_r; len_nxt = len_r + LW'(1);
          end
        end else state_nxt = S_DONE;
      end
      S_FIND: begin
        if (!busy_r[find_r]) begin
          pr_we = 1'b1; od_we = 1'b1;
          rl_we = 1'b1; len_nxt = len_r + LW'(1);
          state_nxt = S_DONE;
        end else if (find_r == PW'(MAX_THREADS - 1)) state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (len_r == '0) state_nxt = S_DONE;
        else if (idx_r == len_r) state_nxt = S_PSL;
        else begin
          idx_nxt = idx_r + LW'(1);
          state_nxt = S_SCANW;
        end
      end
      S_SCANW: begin
        // list entry is out; address prio/order by it
        state_nxt = S_SCAN;
      end
      S_PSL: begin
        idx_nxt = best_r;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (idx_r + LW'(1) >= len_r) begin
          len_nxt = len_r - LW'(1);
          state_nxt = S_DONE;
        end else begin
          rl_ra = PW'(idx_r + LW'(1));
          state_nxt = S_SHW;
        end
      end
      S_SHW: begin
        rl_we = 1'b1; rl_wa = idx_r[PW-1:0]; rl_wd = rl_rd;
        idx_nxt = idx_r + LW'(1);
        state_nxt = S_SHIFT;
      end
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX_THREADS)) else $error("ready list overflow");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> busy_r[cur_pid_r]) else $error("running thread slot free");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r) else $error("result dropped");
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> state_r != S_IDLE) else $error("item lost");
endmodule

// File: hdl/mpts_ram.sv
module mpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
